// ----- rtl/core/binary_to_decimal_ascii_top_assert.svh -----
// assertion macros for the binary to decimal ascii converter
`ifndef BINARY_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_TOP_ASSERT_SVH

// condition and consequence in the same cycle
`define B2DA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence in the cycle after the condition
`define B2DA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/b2da_pkg.sv -----
// package with types, constants and place weights for the decimal converter
`default_nettype none
package b2da_pkg;

	localparam int DigitCount = 10;
	localparam int Radix = 10;
	localparam int DigitW = 4;
	localparam int PosW = 4;
	localparam int ValueW = 32;
	localparam int WideW = 34;
	localparam int AsciiW = 6;
	localparam int DataW = 8;
	localparam logic [AsciiW-1:0] AsciiZero = 6'h30;
	localparam logic [PosW-1:0] UnitsPos = PosW'(DigitCount - 1);

	typedef struct packed {
		logic [ValueW-1:0] rest;
		logic [DigitCount*DigitW-1:0] digits;
		logic [PosW-1:0] start;
		logic seen;
	} item_t;

	function automatic logic [WideW-1:0] place_multiple(input int pos, input int k);
		logic [WideW-1:0] w;
		case (pos)
			0: w = 34'd1000000000;
			1: w = 34'd100000000;
			2: w = 34'd10000000;
			3: w = 34'd1000000;
			4: w = 34'd100000;
			5: w = 34'd10000;
			6: w = 34'd1000;
			7: w = 34'd100;
			8: w = 34'd10;
			default: w = 34'd1;
		endcase
		return w * WideW'(k);
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/b2da_cell.sv -----
// one decimal place cell: extracts the digit of its place and passes the rest on
`default_nettype none
module b2da_cell #(
	parameter int POS = 0
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire b2da_pkg::item_t in_item,
	output logic out_valid,
	input wire logic out_ready,
	output b2da_pkg::item_t out_item
);

	localparam int DW = b2da_pkg::DigitW;
	localparam int PW = b2da_pkg::PosW;
	localparam int VW = b2da_pkg::ValueW;
	localparam int WW = b2da_pkg::WideW;

	logic valid_q;
	b2da_pkg::item_t item_q;
	b2da_pkg::item_t nxt;
	logic [DW-1:0] digit;
	logic [WW-1:0] sub;

	assign in_ready = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_item = item_q;

	always_comb begin
		digit = '0;
		sub = '0;
		for (int k = 1; k < b2da_pkg::Radix; k++) begin
			if ({2'b00, in_item.rest} >= b2da_pkg::place_multiple(POS, k)) begin
				digit = DW'(k);
				sub = b2da_pkg::place_multiple(POS, k);
			end
		end
		nxt = in_item;
		nxt.rest = in_item.rest - sub[VW-1:0];
		nxt.digits[POS*DW +: DW] = digit;
		nxt.seen = in_item.seen || (digit != '0);
		if (!nxt.seen && (POS != b2da_pkg::DigitCount - 1)) begin
			nxt.start = PW'(POS + 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_q <= nxt;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/b2da_emit.sv -----
// character emitter: holds one number's digits and sends them one per transaction
`default_nettype none
module b2da_emit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire b2da_pkg::item_t in_item,
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [b2da_pkg::DataW-1:0] m_tdata,
	output logic m_tlast
);

	localparam int DW = b2da_pkg::DigitW;
	localparam int PW = b2da_pkg::PosW;

	logic busy_q;
	logic [PW-1:0] pos_q;
	logic [b2da_pkg::DigitCount*DW-1:0] digits_q;
	logic [DW-1:0] digit;
	logic sent;
	logic done;

	assign digit = digits_q[pos_q*DW +: DW];
	assign m_tvalid = busy_q;
	assign m_tlast = (pos_q == b2da_pkg::UnitsPos);
	assign m_tdata = {2'b00, b2da_pkg::AsciiZero + {2'b00, digit}};
	assign sent = busy_q && m_tready;
	assign done = sent && m_tlast;
	assign in_ready = !busy_q || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q <= '0;
		end else if (in_ready && in_valid) begin
			busy_q <= 1'b1;
			pos_q <= in_item.start;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (sent) begin
			pos_q <= pos_q + PW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			digits_q <= in_item.digits;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/binary_to_decimal_ascii_top.sv -----
// top level: ten place cells in a row followed by the character emitter
// first character is valid once the value has passed all cells and entered the emitter
// throughput: one character per cycle while m_tready is high; k digits give k characters
// the single output character port sets the rate, 1 to 10 characters per value
// reset clears the valid flags of the cells and the emitter; digit data is not reset
`default_nettype none
`include "binary_to_decimal_ascii_top_assert.svh"
module binary_to_decimal_ascii_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [31:0] s_tdata, // value[31:0]
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [7:0] m_tdata, // ascii_digit[5:0], zero fill[7:6]
	output logic m_tlast // last_digit
);

	localparam int N = b2da_pkg::DigitCount;

	logic chain_valid [N+1];
	logic chain_ready [N+1];
	b2da_pkg::item_t chain_item [N+1];

	assign chain_valid[0] = s_tvalid;
	assign s_tready = chain_ready[0];
	assign chain_item[0] = '{rest: s_tdata, digits: '0, start: '0, seen: 1'b0};

	for (genvar i = 0; i < N; i++) begin : g_cell
		b2da_cell #(
			.POS(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.in_valid(chain_valid[i]),
			.in_ready(chain_ready[i]),
			.in_item(chain_item[i]),
			.out_valid(chain_valid[i+1]),
			.out_ready(chain_ready[i+1]),
			.out_item(chain_item[i+1])
		);
	end

	b2da_emit u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(chain_valid[N]),
		.in_ready(chain_ready[N]),
		.in_item(chain_item[N]),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	`B2DA_ASSERT_SAME(a_digit_range, m_tvalid,
		(m_tdata >= 8'h30) && (m_tdata <= 8'h39), "character outside 0 to 9")
	`B2DA_ASSERT_NEXT(a_no_gap, m_tvalid && m_tready && !m_tlast, m_tvalid,
		"gap inside a number")
	`B2DA_ASSERT_SAME(a_start_range, chain_valid[N],
		chain_item[N].start <= b2da_pkg::UnitsPos, "start position past units digit")

endmodule
`default_nettype wire
